// ===== src/rfd_pkg.sv =====
package rfd_pkg;

    localparam int CODE_BITS  = 5;
    localparam int TIMER_W    = 16;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    localparam logic [7:0] SPEED_NORMAL_RST    = 8'd60;
    localparam logic [7:0] SPEED_FAST_RST      = 8'd200;
    localparam logic [7:0] SPEED_TURN_SLOW_RST = 8'd30;
    localparam logic [7:0] PWM_WRAP_RST        = 8'd201;
    localparam logic [7:0] FIRST_SAMPLE_RST    = 8'd15;
    localparam logic [5:0] SAMPLE_SPACING_RST  = 6'd6;
    localparam logic [9:0] FRAME_END_RST       = 10'd45;
    localparam logic [9:0] IDLE_CLEAR_RST      = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_NORMAL    = 3'd0,
        CFG_SPEED_FAST      = 3'd1,
        CFG_SPEED_TURN_SLOW = 3'd2,
        CFG_PWM_WRAP        = 3'd3,
        CFG_FIRST_SAMPLE    = 3'd4,
        CFG_SAMPLE_SPACING  = 3'd5,
        CFG_FRAME_END       = 3'd6,
        CFG_IDLE_CLEAR      = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    typedef struct packed {
        logic func;
        logic rc_level;
    } t_in_beat;

    typedef struct packed {
        logic       left_enable;
        logic       left_forward;
        logic       left_backward;
        logic       right_enable;
        logic       right_forward;
        logic       right_backward;
        logic [4:0] command_code;
        logic       receiving;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] speed_normal;
        logic [7:0] speed_fast;
        logic [7:0] speed_turn_slow;
        logic [7:0] pwm_wrap;
        logic [7:0] first_sample_time;
        logic [5:0] sample_spacing;
        logic [9:0] frame_end_time;
        logic [9:0] idle_clear_time;
    } t_cfg;

    typedef struct packed {
        logic [TIMER_W-1:0]   timer;
        logic                 active;
        logic [CODE_BITS-1:0] code;
    } t_frame;

    typedef struct packed {
        t_dir       dir;
        logic [7:0] thr;
    } t_drive;

    typedef struct packed {
        logic [7:0] count;
        logic       enable;
        logic       forward;
        logic       backward;
    } t_motor;

endpackage

// ===== src/rfd_frame.sv =====
module rfd_frame (
    input  rfd_pkg::t_frame   i_cur,
    input  rfd_pkg::t_in_beat i_beat,
    input  rfd_pkg::t_cfg     i_cfg,
    output rfd_pkg::t_frame   o_nxt
);

    always_comb begin
        logic [rfd_pkg::TIMER_W-1:0] when_k;
        when_k = '0;
        o_nxt  = i_cur;
        if (!i_beat.func) begin
            o_nxt.timer = i_cur.timer + 16'd1;
        end else begin
            // high level while idle opens a frame
            if (i_beat.rc_level && !o_nxt.active) begin
                o_nxt.timer  = 16'd1;
                o_nxt.active = 1'b1;
            end
            if (o_nxt.active) begin
                for (int k = 0; k < rfd_pkg::CODE_BITS; k++) begin
                    when_k = 16'(i_cfg.first_sample_time)
                           + 16'(k) * 16'(i_cfg.sample_spacing);
                    if (o_nxt.timer == when_k) begin
                        o_nxt.code[k] = i_beat.rc_level;
                    end
                end
            end
            if (o_nxt.active && o_nxt.timer == 16'(i_cfg.frame_end_time)) begin
                o_nxt.active = 1'b0;
            end
            if (!o_nxt.active && o_nxt.timer == 16'(i_cfg.idle_clear_time)) begin
                o_nxt.code = '0;
            end
        end
    end

endmodule

// ===== src/rfd_decode.sv =====
module rfd_decode (
    input  logic [4:0]      i_code,
    input  rfd_pkg::t_cfg   i_cfg,
    output rfd_pkg::t_drive o_left,
    output rfd_pkg::t_drive o_right
);

    always_comb begin
        logic [7:0] base_thr;
        base_thr = i_code[4] ? i_cfg.speed_fast : i_cfg.speed_normal;

        if (i_code[2]) begin
            o_left.dir = rfd_pkg::DIR_BACK;
        end else if (i_code[0]) begin
            o_left.dir = rfd_pkg::DIR_FWD;
        end else begin
            o_left.dir = rfd_pkg::DIR_STOP;
        end
        if (i_code[3]) begin
            o_right.dir = rfd_pkg::DIR_BACK;
        end else if (i_code[1]) begin
            o_right.dir = rfd_pkg::DIR_FWD;
        end else begin
            o_right.dir = rfd_pkg::DIR_STOP;
        end
        o_left.thr  = base_thr;
        o_right.thr = base_thr;

        // single forward bit set: turn with outer wheel fast
        if (i_code[3:0] == 4'b0001) begin
            o_left.dir  = rfd_pkg::DIR_FWD;
            o_right.dir = rfd_pkg::DIR_FWD;
            o_left.thr  = i_cfg.speed_fast;
            o_right.thr = i_cfg.speed_turn_slow;
        end
        if (i_code[3:0] == 4'b0010) begin
            o_left.dir  = rfd_pkg::DIR_FWD;
            o_right.dir = rfd_pkg::DIR_FWD;
            o_left.thr  = i_cfg.speed_turn_slow;
            o_right.thr = i_cfg.speed_fast;
        end
    end

endmodule

// ===== src/rfd_motor.sv =====
module rfd_motor (
    input  rfd_pkg::t_motor i_cur,
    input  rfd_pkg::t_drive i_drive,
    input  logic [7:0]      i_wrap,
    output rfd_pkg::t_motor o_nxt
);

    always_comb begin
        logic [7:0] cnt_inc;
        cnt_inc = i_cur.count + 8'd1;
        o_nxt   = i_cur;
        if (cnt_inc <= i_drive.thr) begin
            o_nxt.enable = 1'b1;
            case (i_drive.dir)
                rfd_pkg::DIR_STOP: begin
                    o_nxt.forward  = 1'b0;
                    o_nxt.backward = 1'b0;
                end
                rfd_pkg::DIR_FWD: begin
                    o_nxt.forward  = 1'b1;
                    o_nxt.backward = 1'b0;
                end
                rfd_pkg::DIR_BACK: begin
                    o_nxt.forward  = 1'b0;
                    o_nxt.backward = 1'b1;
                end
                default: begin
                    // hold direction pins
                end
            endcase
        end else begin
            o_nxt.enable = 1'b0;
        end
        o_nxt.count = (cnt_inc == i_wrap) ? 8'd0 : cnt_inc;
    end

endmodule

// ===== src/remote_frame_decoder_motor_pwm.sv =====
// Remote frame decoder with two-motor PWM. Each input beat is a slow tick
// (advance the frame timer) or a fast tick (sample the remote level, decode
// the command while idle, step both duty counters). Each beat yields exactly
// one result beat with the pin levels, command code and receive flag after
// that tick. A beat can be accepted every cycle while the output is not
// stalled. An accepted beat sits in an input register, and its result is
// loaded into the output register, raising o_out_valid, once that register
// is free or being taken. Back-pressure on the output stalls the input
// register, which still takes one more beat while a result waits. The user
// must write configuration registers through the write port only while no
// beat is in flight; the block itself does not enforce this.
module remote_frame_decoder_motor_pwm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rfd_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rfd_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    rfd_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    rfd_pkg::t_in_beat  r_in;
    logic               r_out_valid;
    rfd_pkg::t_out_beat r_out;

    rfd_pkg::t_frame    r_frame;
    rfd_pkg::t_drive    r_left_drive;
    rfd_pkg::t_drive    r_right_drive;
    rfd_pkg::t_motor    r_left;
    rfd_pkg::t_motor    r_right;

    rfd_pkg::t_frame    n_frame;
    rfd_pkg::t_drive    n_left_drive;
    rfd_pkg::t_drive    n_right_drive;
    rfd_pkg::t_motor    n_left;
    rfd_pkg::t_motor    n_right;
    rfd_pkg::t_out_beat n_out;

    rfd_pkg::t_drive    w_dec_left;
    rfd_pkg::t_drive    w_dec_right;
    rfd_pkg::t_motor    w_pwm_left;
    rfd_pkg::t_motor    w_pwm_right;
    logic               w_adv;
    logic               w_decode;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    rfd_frame u_frame (
        .i_cur  (r_frame),
        .i_beat (r_in),
        .i_cfg  (r_cfg),
        .o_nxt  (n_frame)
    );

    rfd_decode u_decode (
        .i_code  (n_frame.code),
        .i_cfg   (r_cfg),
        .o_left  (w_dec_left),
        .o_right (w_dec_right)
    );

    assign w_decode      = r_in.func && !n_frame.active;
    assign n_left_drive  = w_decode ? w_dec_left  : r_left_drive;
    assign n_right_drive = w_decode ? w_dec_right : r_right_drive;

    rfd_motor u_motor_left (
        .i_cur   (r_left),
        .i_drive (n_left_drive),
        .i_wrap  (r_cfg.pwm_wrap),
        .o_nxt   (w_pwm_left)
    );

    rfd_motor u_motor_right (
        .i_cur   (r_right),
        .i_drive (n_right_drive),
        .i_wrap  (r_cfg.pwm_wrap),
        .o_nxt   (w_pwm_right)
    );

    // slow tick leaves counters and pins alone
    assign n_left  = r_in.func ? w_pwm_left  : r_left;
    assign n_right = r_in.func ? w_pwm_right : r_right;

    always_comb begin
        n_out.left_enable    = n_left.enable;
        n_out.left_forward   = n_left.forward;
        n_out.left_backward  = n_left.backward;
        n_out.right_enable   = n_right.enable;
        n_out.right_forward  = n_right.forward;
        n_out.right_backward = n_right.backward;
        n_out.command_code   = n_frame.code;
        n_out.receiving      = n_frame.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_normal      <= rfd_pkg::SPEED_NORMAL_RST;
            r_cfg.speed_fast        <= rfd_pkg::SPEED_FAST_RST;
            r_cfg.speed_turn_slow   <= rfd_pkg::SPEED_TURN_SLOW_RST;
            r_cfg.pwm_wrap          <= rfd_pkg::PWM_WRAP_RST;
            r_cfg.first_sample_time <= rfd_pkg::FIRST_SAMPLE_RST;
            r_cfg.sample_spacing    <= rfd_pkg::SAMPLE_SPACING_RST;
            r_cfg.frame_end_time    <= rfd_pkg::FRAME_END_RST;
            r_cfg.idle_clear_time   <= rfd_pkg::IDLE_CLEAR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rfd_pkg::CFG_SPEED_NORMAL:    r_cfg.speed_normal      <= i_cfg_wdata[7:0];
                rfd_pkg::CFG_SPEED_FAST:      r_cfg.speed_fast        <= i_cfg_wdata[7:0];
                rfd_pkg::CFG_SPEED_TURN_SLOW: r_cfg.speed_turn_slow   <= i_cfg_wdata[7:0];
                rfd_pkg::CFG_PWM_WRAP:        r_cfg.pwm_wrap          <= i_cfg_wdata[7:0];
                rfd_pkg::CFG_FIRST_SAMPLE:    r_cfg.first_sample_time <= i_cfg_wdata[7:0];
                rfd_pkg::CFG_SAMPLE_SPACING:  r_cfg.sample_spacing    <= i_cfg_wdata[5:0];
                rfd_pkg::CFG_FRAME_END:       r_cfg.frame_end_time    <= i_cfg_wdata;
                rfd_pkg::CFG_IDLE_CLEAR:      r_cfg.idle_clear_time   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // commit the tick to the block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame           <= '0;
            r_left_drive.dir  <= rfd_pkg::DIR_STOP;
            r_left_drive.thr  <= rfd_pkg::SPEED_NORMAL_RST;
            r_right_drive.dir <= rfd_pkg::DIR_STOP;
            r_right_drive.thr <= rfd_pkg::SPEED_NORMAL_RST;
            r_left            <= '0;
            r_right           <= '0;
        end else if (w_adv) begin
            r_frame       <= n_frame;
            r_left_drive  <= n_left_drive;
            r_right_drive <= n_right_drive;
            r_left        <= n_left;
            r_right       <= n_right;
        end
    end

endmodule
